FILE: sv/dmbd_pkg.sv
// ----------------------------------------------------------------------------
// dmbd_pkg
// Shared types, codes and sizes of the display message blink decoder.
// ----------------------------------------------------------------------------
package dmbd_pkg;

  // text line size and derived widths
  localparam int TEXT_CHARS = 14;
  localparam int CNT_W      = $clog2(TEXT_CHARS + 1);
  localparam int POS_W      = $clog2(TEXT_CHARS);
  localparam int MASK_W     = 16;
  localparam int MASK_IW    = 4;

  // request types
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_CTRL = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_BAR_OFF = 2'd1;
  localparam logic [1:0] KIND_BAR_ON  = 2'd2;

  // message byte codes
  localparam logic [7:0] MB_END         = 8'h00;
  localparam logic [7:0] MB_NOP         = 8'h81;
  localparam logic [7:0] MB_PERIOD      = 8'h84;
  localparam logic [7:0] MB_COMMA       = 8'h86;
  localparam logic [7:0] MB_COLON       = 8'h8c;
  localparam logic [7:0] MB_COLON_BLINK = 8'h8d;

  // characters
  localparam logic [7:0] CH_PERIOD = 8'h2e;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // control words
  localparam logic [15:0] CW_BAR_OFF = 16'h712b;
  localparam logic [15:0] CW_BAR_ON  = 16'h002b;
  localparam int          N_BLINK_CODES = 12;
  localparam logic [15:0] BLINK_CODES [N_BLINK_CODES] = '{
    16'h0049, 16'h7149, 16'h6249, 16'h1349, 16'h5449, 16'h2549,
    16'h3649, 16'h4749, 16'h3849, 16'h4949, 16'h5a49, 16'h2b49
  };

  // one result word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic [3:0] pos;
    logic       dim;
    logic       last;
  } res_t;

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_PERIOD) || (c == CH_COMMA) || (c == CH_COLON);
  endfunction

endpackage

FILE: sv/dmbd_req_if.sv
// ----------------------------------------------------------------------------
// dmbd_req_if
// Request channel: message bytes, control words and blink ticks.
// ----------------------------------------------------------------------------
interface dmbd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  msg_byte;
  logic [15:0] ctrl_word;

  modport source (output valid, req_type, msg_byte, ctrl_word, input ready);
  modport sink   (input valid, req_type, msg_byte, ctrl_word, output ready);
endinterface

FILE: sv/dmbd_res_if.sv
// ----------------------------------------------------------------------------
// dmbd_res_if
// Result channel: character writes and bargraph events.
// ----------------------------------------------------------------------------
interface dmbd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] char_code;
  logic [3:0] char_pos;
  logic       dim;
  logic       last;

  modport source (output valid, out_kind, char_code, char_pos, dim, last, input ready);
  modport sink   (input valid, out_kind, char_code, char_pos, dim, last, output ready);
endinterface

FILE: sv/display_message_blink_decoder.sv
// A stored character is registered as the pending word, then in the output
// register. One request at a time: a character or bargraph word is emitted
// from the pending word, an end of message pads each cell after the stored
// ones, a blink tick reads then tests each stored character and emits each
// redrawn one. Output stalls hold the sequencer. Reset clears all control
// state; the character buffer, undefined until written, needs no clearing pass.
// ----------------------------------------------------------------------------
// display_message_blink_decoder
// Turns panel display bytes into character writes, handles blink control
// words and redraws masked characters on each blink tick.
// ----------------------------------------------------------------------------
module display_message_blink_decoder
  import dmbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dmbd_req_if.sink   req,
  dmbd_res_if.source res
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EMIT = 5'b00010,
    ST_PAD  = 5'b00100,
    ST_RD   = 5'b01000,
    ST_CHK  = 5'b10000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [MASK_W-1:0]  mask;
  logic               phase;
  logic               running;
  logic               start_pending;
  logic [CNT_W-1:0]   idx;
  logic [MASK_IW-1:0] k;
  res_t               pend;
  logic               pend_valid;

  logic               accept;
  logic               push;
  logic               room;
  res_t               word;
  logic               ram_we;
  logic               ram_re;
  logic [7:0]         rdata;

  // message byte decode
  logic [CNT_W-1:0]   cnt_eff;
  logic [MASK_W-1:0]  mask_eff;
  logic               running_eff;
  logic [MASK_W-1:0]  mask_byte;
  logic               store;
  logic [7:0]         store_char;
  logic               fits;

  // control word decode
  logic [MASK_W-1:0]  mask_ctrl;

  // blink scan
  logic               punct;
  logic               hit;
  logic               stall;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  // effect of a new message start
  always_comb begin
    cnt_eff     = start_pending ? '0 : cnt;
    mask_eff    = start_pending ? '0 : mask;
    running_eff = start_pending ? 1'b0 : running;
    mask_byte   = mask_eff;
    store       = 1'b1;
    store_char  = req.msg_byte;
    unique case (req.msg_byte)
      MB_PERIOD: store_char = CH_PERIOD;
      MB_COMMA:  store_char = CH_COMMA;
      MB_COLON:  store_char = CH_COLON;
      MB_COLON_BLINK: begin
        store_char = CH_COLON;
        if (cnt_eff != '0) begin
          mask_byte = mask_eff | (MASK_W'(1) << MASK_IW'(cnt_eff - CNT_W'(1)));
        end
      end
      MB_NOP, MB_END: store = 1'b0;
      default: store_char = req.msg_byte;
    endcase
    fits = (cnt_eff < CNT_W'(TEXT_CHARS));
  end

  // blink code match
  always_comb begin
    mask_ctrl = mask;
    for (int i = 0; i < N_BLINK_CODES; i++) begin
      if (req.ctrl_word == BLINK_CODES[i]) begin
        mask_ctrl[i] = 1'b1;
      end
    end
  end

  // scan test on the word read back
  assign punct = is_punct(rdata);
  assign hit   = !punct && mask[k];
  assign stall = push && !room;

  // result word selection
  always_comb begin
    push = 1'b0;
    word = pend;
    unique case (state)
      ST_EMIT: push = 1'b1;
      ST_PAD: begin
        push      = 1'b1;
        word.kind = KIND_CHAR;
        word.code = CH_SPACE;
        word.pos  = 4'(idx);
        word.dim  = 1'b0;
        word.last = (idx == CNT_W'(TEXT_CHARS - 1));
      end
      ST_CHK: begin
        push      = hit && pend_valid;
        word.last = 1'b0;
      end
      default: push = 1'b0;
    endcase
  end

  // buffer ports
  assign ram_we = accept && (req.req_type == REQ_BYTE) && store && fits;
  assign ram_re = (state == ST_RD) && (idx != cnt);

  dmbd_text_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (POS_W'(cnt_eff)),
    .wdata (store_char),
    .re    (ram_re),
    .raddr (POS_W'(idx)),
    .rdata (rdata)
  );

  dmbd_out_stage u_out (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .word (word),
    .room (room),
    .res  (res)
  );

  // sequencer and message state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      mask          <= '0;
      phase         <= 1'b0;
      running       <= 1'b0;
      start_pending <= 1'b1;
      pend_valid    <= 1'b0;
      idx           <= '0;
      k             <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (req.req_type)
              REQ_BYTE: begin
                start_pending <= 1'b0;
                cnt           <= cnt_eff;
                mask          <= mask_byte;
                running       <= running_eff;
                if (store && fits) begin
                  pend  <= '{kind: KIND_CHAR, code: store_char, pos: 4'(cnt_eff),
                             dim: 1'b0, last: 1'b1};
                  cnt   <= cnt_eff + CNT_W'(1);
                  state <= ST_EMIT;
                end
                if (req.msg_byte == MB_END) begin
                  start_pending <= 1'b1;
                  if (mask_byte != '0) begin
                    running <= 1'b1;
                  end
                  idx <= cnt_eff;
                  if (fits) begin
                    state <= ST_PAD;
                  end
                end
              end
              REQ_CTRL: begin
                mask <= mask_ctrl;
                if (mask_ctrl != '0) begin
                  running <= 1'b1;
                end
                if (req.ctrl_word == CW_BAR_OFF) begin
                  pend  <= '{kind: KIND_BAR_OFF, code: 8'd0, pos: 4'd0,
                             dim: 1'b0, last: 1'b1};
                  state <= ST_EMIT;
                end else if (req.ctrl_word == CW_BAR_ON) begin
                  pend  <= '{kind: KIND_BAR_ON, code: 8'd0, pos: 4'd0,
                             dim: 1'b0, last: 1'b1};
                  state <= ST_EMIT;
                end
              end
              REQ_TICK: begin
                if (running) begin
                  phase      <= !phase;
                  idx        <= '0;
                  k          <= '0;
                  pend_valid <= 1'b0;
                  state      <= ST_RD;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_EMIT: begin
          if (room) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        ST_PAD: begin
          if (room) begin
            idx <= idx + CNT_W'(1);
            if (idx == CNT_W'(TEXT_CHARS - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_RD: begin
          if (idx == cnt) begin
            state <= pend_valid ? ST_EMIT : ST_IDLE;
          end else begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (!stall) begin
            if (!punct) begin
              k <= k + MASK_IW'(1);
            end
            if (hit) begin
              pend       <= '{kind: KIND_CHAR, code: rdata, pos: 4'(idx),
                              dim: phase, last: 1'b1};
              pend_valid <= 1'b1;
            end
            idx   <= idx + CNT_W'(1);
            state <= ST_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/dmbd_text_ram.sv
// ----------------------------------------------------------------------------
// dmbd_text_ram
// Character buffer of the text line, one write and one registered read port.
// ----------------------------------------------------------------------------
module dmbd_text_ram
  import dmbd_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [POS_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [POS_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [TEXT_CHARS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/dmbd_out_stage.sv
// ----------------------------------------------------------------------------
// dmbd_out_stage
// Output register of the result channel; takes a new word as the old leaves.
// ----------------------------------------------------------------------------
module dmbd_out_stage
  import dmbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  res_t  word,
  output logic  room,
  dmbd_res_if.source res
);

  logic full;
  res_t held;

  assign room = !full || res.ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push && room) begin
      full <= 1'b1;
    end else if (res.ready) begin
      full <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push && room) begin
      held <= word;
    end
  end

  assign res.valid     = full;
  assign res.out_kind  = held.kind;
  assign res.char_code = held.code;
  assign res.char_pos  = held.pos;
  assign res.dim       = held.dim;
  assign res.last      = held.last;

endmodule

FILE: bench/display_message_blink_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// display_message_blink_decoder_tb
// Self-checking bench for the panel message decoder. A queue of request
// words (message bytes, control words, blink ticks) feeds a driver. A
// monitor keeps its own model of the text line and blink state, works out
// the owed character and bargraph words, and checks each result word in
// order. Both channels idle at random apart from one steady stretch.
// ----------------------------------------------------------------------------
module display_message_blink_decoder_tb;
  import dmbd_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         IDLE_PCT    = 19;
  localparam int         STALL_LIMIT = 3000;
  localparam int         TAIL_CYCLES = 40;
  localparam int         WORD_TARGET = 370;

  typedef struct {
    logic [1:0]  req_type;
    logic [7:0]  msg_byte;
    logic [15:0] ctrl_word;
    bit          drain_first;
  } panel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dmbd_req_if req_ch ();
  dmbd_res_if res_ch ();

  display_message_blink_decoder DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .res (res_ch.source)
  );

  // stimulus and scoreboard state
  panel_word_t pending_words [$];
  panel_word_t next_word;
  res_t        owed_writes [$];
  res_t        held_write;
  bit          holding;
  bit          drain_next;
  int          word_n;
  int          owed_n;
  int          taken_n;
  int          mismatch_n;
  int          stall_cycles;

  // model of the text line
  logic [7:0]        line_buf [TEXT_CHARS];
  int                line_len;
  logic [MASK_W-1:0] blink_bits;
  logic              blink_dim;
  logic              blink_on;
  logic              new_msg;

  wire steady = (taken_n >= 150) && (taken_n < 230);

  initial forever #1 clk = ~clk;

  // queue one request word; unused fields carry random data
  function automatic void queue_word(logic [1:0] kind, logic [7:0] b, logic [15:0] cw);
    panel_word_t w;
    w.req_type    = kind;
    w.msg_byte    = (kind == REQ_BYTE) ? b : 8'($urandom);
    w.ctrl_word   = (kind == REQ_CTRL) ? cw : 16'($urandom);
    w.drain_first = drain_next;
    drain_next    = 1'b0;
    pending_words.push_back(w);
    if (kind != REQ_UNUSED && !(kind == REQ_BYTE && b == MB_NOP))
      word_n++;
  endfunction

  function automatic logic [15:0] any_blink_code();
    return BLINK_CODES[$urandom_range(N_BLINK_CODES - 1)];
  endfunction

  // well-formed message with random content, blink words and ticks around it
  function automatic void queue_message();
    int          len;
    int          pick;
    logic [7:0]  b;
    len = ($urandom_range(9) == 0) ? $urandom_range(17, 13) : $urandom_range(10, 0);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 50)      b = 8'($urandom_range(126, 33));
      else if (pick < 60) b = MB_PERIOD;
      else if (pick < 68) b = MB_COMMA;
      else if (pick < 76) b = MB_COLON;
      else if (pick < 86) b = MB_COLON_BLINK;
      else if (pick < 90) b = MB_NOP;
      else                b = 8'($urandom_range(255, 1));
      queue_word(REQ_BYTE, b, '0);
      if ($urandom_range(19) == 0) queue_word(REQ_CTRL, '0, any_blink_code());
      if ($urandom_range(24) == 0) queue_word(REQ_TICK, '0, '0);
    end
    queue_word(REQ_BYTE, MB_END, '0);
    repeat ($urandom_range(2)) queue_word(REQ_CTRL, '0, any_blink_code());
    repeat ($urandom_range(3)) queue_word(REQ_TICK, '0, '0);
  endfunction

  // noise: any request type, random bytes and control words
  function automatic void queue_noise();
    int         pick;
    logic [15:0] cw;
    pick = $urandom_range(99);
    if (pick < 20)      cw = CW_BAR_OFF;
    else if (pick < 40) cw = CW_BAR_ON;
    else                cw = 16'($urandom);
    queue_word(2'($urandom_range(3)), 8'($urandom), cw);
  endfunction

  // result bookkeeping: the final word of each request carries last
  function automatic void owe_write(logic [1:0] kind, logic [7:0] code, int pos, logic dim);
    if (holding) owed_writes.push_back(held_write);
    held_write.kind = kind;
    held_write.code = code;
    held_write.pos  = 4'(pos);
    held_write.dim  = dim;
    held_write.last = 1'b0;
    holding = 1'b1;
  endfunction

  function automatic void store_on_line(logic [7:0] c);
    if (line_len < TEXT_CHARS) begin
      line_buf[line_len] = c;
      owe_write(KIND_CHAR, c, line_len, 1'b0);
      line_len++;
    end
  endfunction

  // predicted panel writes for one accepted request
  function automatic void predict_panel_writes(logic [1:0] kind, logic [7:0] b, logic [15:0] cw);
    int k;
    holding = 1'b0;
    if (kind == REQ_BYTE) begin
      if (new_msg) begin
        line_len   = 0;
        blink_bits = '0;
        blink_on   = 1'b0;
        new_msg    = 1'b0;
      end
      case (b)
        MB_PERIOD: store_on_line(CH_PERIOD);
        MB_COMMA:  store_on_line(CH_COMMA);
        MB_COLON:  store_on_line(CH_COLON);
        MB_COLON_BLINK: begin
          // blink bit of the previous cell, none at line start
          if (line_len > 0) blink_bits[line_len - 1] = 1'b1;
          store_on_line(CH_COLON);
        end
        MB_NOP: ;
        MB_END: begin
          for (int i = line_len; i < TEXT_CHARS; i++)
            owe_write(KIND_CHAR, CH_SPACE, i, 1'b0);
          if (blink_bits != '0) blink_on = 1'b1;
          new_msg = 1'b1;
        end
        default: store_on_line(b);
      endcase
    end else if (kind == REQ_CTRL) begin
      for (int i = 0; i < N_BLINK_CODES; i++)
        if (cw == BLINK_CODES[i]) blink_bits[i] = 1'b1;
      if (cw == CW_BAR_OFF)
        owe_write(KIND_BAR_OFF, '0, 0, 1'b0);
      else if (cw == CW_BAR_ON)
        owe_write(KIND_BAR_ON, '0, 0, 1'b0);
      if (blink_bits != '0) blink_on = 1'b1;
    end else if (kind == REQ_TICK && blink_on) begin
      // punctuation is skipped and does not use a mask bit
      blink_dim = ~blink_dim;
      k = 0;
      for (int i = 0; i < line_len; i++) begin
        if (!(line_buf[i] == CH_PERIOD || line_buf[i] == CH_COMMA
              || line_buf[i] == CH_COLON)) begin
          if (k < MASK_W && blink_bits[k])
            owe_write(KIND_CHAR, line_buf[i], i, blink_dim);
          k++;
        end
      end
    end
    if (holding) begin
      held_write.last = 1'b1;
      owed_writes.push_back(held_write);
      holding = 1'b0;
    end
  endfunction

  function automatic void log_mismatch(string msg);
    mismatch_n++;
    if (mismatch_n <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  function automatic string show_write(res_t w);
    return $sformatf("kind %0d code %02h pos %0d dim %0b last %0b",
                     w.kind, w.code, w.pos, w.dim, w.last);
  endfunction

  // compare one accepted result word with the oldest owed one
  function automatic void check_write();
    res_t got;
    res_t want;
    got.kind = res_ch.out_kind;
    got.code = res_ch.char_code;
    got.pos  = res_ch.char_pos;
    got.dim  = res_ch.dim;
    got.last = res_ch.last;
    if (owed_writes.size() == 0) begin
      log_mismatch({"word with none owed: ", show_write(got)});
    end else begin
      want = owed_writes.pop_front();
      if (got.kind !== want.kind || got.code !== want.code || got.pos !== want.pos
          || got.dim !== want.dim || got.last !== want.last)
        log_mismatch({"expected ", show_write(want), ", got ", show_write(got)});
    end
  endfunction

  // driver: hold each word until accepted, idle at random
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_words.size() > 0
          && (!pending_words[0].drain_first || (!req_ch.valid && owed_n == 0))
          && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        next_word = pending_words.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= next_word.req_type;
        req_ch.msg_byte  <= next_word.msg_byte;
        req_ch.ctrl_word <= next_word.ctrl_word;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      owed_n       <= 0;
      taken_n      <= 0;
      line_len     = 0;
      blink_bits   = '0;
      blink_dim    = 1'b0;
      blink_on     = 1'b0;
      new_msg      = 1'b1;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_panel_writes(req_ch.req_type, req_ch.msg_byte, req_ch.ctrl_word);
        taken_n <= taken_n + 1;
      end
      if (res_ch.valid && res_ch.ready) check_write();
      owed_n       <= owed_writes.size();
      res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL display_message_blink_decoder");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int next_drain;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_BYTE;
    req_ch.msg_byte  = '0;
    req_ch.ctrl_word = '0;
    res_ch.ready     = 1'b0;
    mismatch_n       = 0;
    word_n           = 0;
    drain_next       = 1'b0;
    holding          = 1'b0;

    // directed: tick before any blinking, unused request type
    queue_word(REQ_TICK, '0, '0);
    queue_word(REQ_UNUSED, '0, '0);
    // colon-blink at line start, all punctuation codes, nop, top byte
    queue_word(REQ_BYTE, MB_COLON_BLINK, '0);
    queue_word(REQ_BYTE, 8'h41, '0);
    queue_word(REQ_BYTE, MB_PERIOD, '0);
    queue_word(REQ_BYTE, MB_COMMA, '0);
    queue_word(REQ_BYTE, MB_COLON, '0);
    queue_word(REQ_BYTE, MB_COLON_BLINK, '0);
    queue_word(REQ_BYTE, MB_NOP, '0);
    queue_word(REQ_BYTE, 8'hff, '0);
    // fill the line, then a dropped char and a colon-blink on a full line
    for (int i = 0; i < 7; i++) queue_word(REQ_BYTE, 8'(8'h30 + i), '0);
    queue_word(REQ_BYTE, 8'h51, '0);
    queue_word(REQ_BYTE, MB_COLON_BLINK, '0);
    queue_word(REQ_BYTE, MB_END, '0);
    queue_word(REQ_TICK, '0, '0);
    // tick in the middle of a message, then padding
    queue_word(REQ_BYTE, 8'h58, '0);
    queue_word(REQ_CTRL, '0, BLINK_CODES[0]);
    queue_word(REQ_TICK, '0, '0);
    queue_word(REQ_BYTE, 8'h01, '0);
    queue_word(REQ_BYTE, MB_END, '0);
    // bargraph events, unknown word, last blink code
    queue_word(REQ_CTRL, '0, CW_BAR_OFF);
    queue_word(REQ_CTRL, '0, CW_BAR_ON);
    queue_word(REQ_CTRL, '0, 16'hffff);
    queue_word(REQ_CTRL, '0, BLINK_CODES[N_BLINK_CODES - 1]);
    queue_word(REQ_TICK, '0, '0);

    // random part, mostly messages, with a drain pause now and then
    next_drain = 120;
    while (word_n < WORD_TARGET) begin
      if (word_n >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 130;
      end
      if ($urandom_range(9) < 7) queue_message();
      else repeat ($urandom_range(3, 1)) queue_noise();
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || req_ch.valid) @(negedge clk);
    while (owed_n != 0 || owed_writes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_n == 0 && owed_writes.size() == 0) begin
      $display("PASS display_message_blink_decoder");
    end else begin
      $display("FAIL display_message_blink_decoder");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/dmbd_pkg.sv
sv/dmbd_req_if.sv
sv/dmbd_res_if.sv
sv/dmbd_text_ram.sv
sv/dmbd_out_stage.sv
sv/display_message_blink_decoder.sv
bench/display_message_blink_decoder_tb.sv
